/* hdl/frlw_pkg.sv */
// shared constants, codes and controller types for the flash record log writer
`timescale 1ns / 1ps

package frlw_pkg;

  // default geometry
  localparam int unsigned DATA_WORDS_DEF = 8;
  localparam int unsigned PAGE_BYTES_DEF = 2048;

  // record format constants
  localparam logic [31:0] ABANDON_FLAG = 32'hFF55_AA00;
  localparam logic [7:0]  MAGIC_BYTE   = 8'hF5;

  // configuration registers
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 1'b1;

  localparam logic [31:0] REGION_START_RST = 32'h0807_A800;
  localparam logic [8:0]  REGION_PAGES_RST = 9'd11;

  // flash command codes
  localparam logic CMD_ERASE   = 1'b0;
  localparam logic CMD_PROGRAM = 1'b1;

  // record functions
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_FORMAT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_WAIT,
    ST_CMP_ACC,
    ST_DECIDE,
    ST_ABANDON,
    ST_CALC_TAIL,
    ST_CALC_FLAGS,
    ST_SEL_SLOT,
    ST_ERASE,
    ST_ADDR,
    ST_DATA_WAIT,
    ST_DATA_PUT,
    ST_TRAILER
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic stage_we;    // input beat accepted
    logic cmp_acc;     // compare and sum one word
    logic idx_inc;     // step the word index
    logic ld_abandon;  // emit abandon flag, compute next slot and region end
    logic calc_tail;   // compute slot tail and byte before slot
    logic calc_flags;  // compute overflow and page crossing
    logic sel_slot;    // commit the new slot pointer and erase page
    logic fmt_slot;    // slot pointer to region start for a format
    logic ld_erase;    // emit erase
    logic ld_addr;     // first data address, index to zero
    logic ld_data;     // emit one data word and copy it to the stored record
    logic ld_trailer;  // emit trailer, last beat of the commit
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func;
    logic diff;
    logic need_erase;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

/* hdl/frlw_stream_if.sv */
// valid/ready stream interfaces for record words and flash commands
`timescale 1ns / 1ps

interface frlw_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] data_word;
  logic        last;

  modport source (output valid, func, data_word, last, input ready);
  modport sink   (input valid, func, data_word, last, output ready);
endinterface

interface frlw_out_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] flash_address;
  logic [31:0] program_data;
  logic        final_res;

  modport source (output valid, command, flash_address, program_data, final_res,
                  input ready);
  modport sink   (input valid, command, flash_address, program_data, final_res,
                  output ready);
endinterface

/* hdl/frlw_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module frlw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/frlw_ctrl.sv */
// commit sequencer for the record log writer
`timescale 1ns / 1ps

module frlw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  frlw_pkg::status_t status_i,
  output frlw_pkg::cmd_t    cmd_o
);

  frlw_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == frlw_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frlw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      frlw_pkg::ST_IDLE: begin
        if (accept && in_last_i) state_d = frlw_pkg::ST_CMP_WAIT;
      end
      frlw_pkg::ST_CMP_WAIT: state_d = frlw_pkg::ST_CMP_ACC;
      frlw_pkg::ST_CMP_ACC: begin
        state_d = status_i.idx_last ? frlw_pkg::ST_DECIDE : frlw_pkg::ST_CMP_WAIT;
      end
      frlw_pkg::ST_DECIDE: begin
        if (status_i.func == frlw_pkg::FUNC_FORMAT) begin
          state_d = frlw_pkg::ST_ERASE;
        end else if (!status_i.diff) begin
          state_d = frlw_pkg::ST_IDLE;
        end else begin
          state_d = frlw_pkg::ST_ABANDON;
        end
      end
      frlw_pkg::ST_ABANDON: begin
        if (status_i.out_free) state_d = frlw_pkg::ST_CALC_TAIL;
      end
      frlw_pkg::ST_CALC_TAIL:  state_d = frlw_pkg::ST_CALC_FLAGS;
      frlw_pkg::ST_CALC_FLAGS: state_d = frlw_pkg::ST_SEL_SLOT;
      frlw_pkg::ST_SEL_SLOT: begin
        state_d = status_i.need_erase ? frlw_pkg::ST_ERASE : frlw_pkg::ST_ADDR;
      end
      frlw_pkg::ST_ERASE: begin
        if (status_i.out_free) state_d = frlw_pkg::ST_ADDR;
      end
      frlw_pkg::ST_ADDR:      state_d = frlw_pkg::ST_DATA_WAIT;
      frlw_pkg::ST_DATA_WAIT: state_d = frlw_pkg::ST_DATA_PUT;
      frlw_pkg::ST_DATA_PUT: begin
        if (status_i.out_free) begin
          state_d = status_i.idx_last ? frlw_pkg::ST_TRAILER : frlw_pkg::ST_DATA_WAIT;
        end
      end
      frlw_pkg::ST_TRAILER: begin
        if (status_i.out_free) state_d = frlw_pkg::ST_IDLE;
      end
      default: state_d = frlw_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      frlw_pkg::ST_IDLE:     cmd_o.stage_we = accept;
      frlw_pkg::ST_CMP_WAIT: ;
      frlw_pkg::ST_CMP_ACC: begin
        cmd_o.cmp_acc = 1'b1;
        cmd_o.idx_inc = !status_i.idx_last;
      end
      frlw_pkg::ST_DECIDE: begin
        cmd_o.fmt_slot = (status_i.func == frlw_pkg::FUNC_FORMAT);
      end
      frlw_pkg::ST_ABANDON:    cmd_o.ld_abandon = status_i.out_free;
      frlw_pkg::ST_CALC_TAIL:  cmd_o.calc_tail  = 1'b1;
      frlw_pkg::ST_CALC_FLAGS: cmd_o.calc_flags = 1'b1;
      frlw_pkg::ST_SEL_SLOT:   cmd_o.sel_slot   = 1'b1;
      frlw_pkg::ST_ERASE:      cmd_o.ld_erase   = status_i.out_free;
      frlw_pkg::ST_ADDR:       cmd_o.ld_addr    = 1'b1;
      frlw_pkg::ST_DATA_WAIT: ;
      frlw_pkg::ST_DATA_PUT: begin
        cmd_o.ld_data = status_i.out_free;
        cmd_o.idx_inc = status_i.out_free && !status_i.idx_last;
      end
      frlw_pkg::ST_TRAILER: cmd_o.ld_trailer = status_i.out_free;
      default: ;
    endcase
  end

endmodule

/* hdl/frlw_dp.sv */
// record staging, compare, slot arithmetic and command output register
`timescale 1ns / 1ps

module frlw_dp #(
  parameter int unsigned DATA_WORDS = frlw_pkg::DATA_WORDS_DEF,
  parameter int unsigned PAGE_BYTES = frlw_pkg::PAGE_BYTES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [frlw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  // input payload
  input  logic                               in_func_i,
  input  logic [31:0]                        in_data_word_i,
  input  logic                               in_last_i,
  // output beat
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               out_command_o,
  output logic [31:0]                        out_flash_address_o,
  output logic [31:0]                        out_program_data_o,
  output logic                               out_final_res_o,
  // controller link
  input  frlw_pkg::cmd_t                     cmd_i,
  output frlw_pkg::status_t                  status_o
);

  localparam int unsigned AW  = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned WCW = $clog2(DATA_WORDS + 1);
  localparam int unsigned PBL = $clog2(PAGE_BYTES);
  localparam logic [31:0] SLOT_BYTES   = 32'(4 * DATA_WORDS + 8);
  localparam logic [31:0] SLOT_LAST    = 32'(4 * DATA_WORDS + 7);
  localparam logic [31:0] PAGE_MASK    = ~32'(PAGE_BYTES - 1);
  localparam logic [AW-1:0]  IDX_LAST  = AW'(DATA_WORDS - 1);
  localparam logic [WCW-1:0] WC_FULL   = WCW'(DATA_WORDS);

  // configuration and control state
  logic [31:0]    region_start_q;
  logic [8:0]     region_pages_q;
  logic [WCW-1:0] word_count_q;
  logic           func_q;
  logic [31:0]    slot_q;
  logic [AW-1:0]  idx_q;
  logic           diff_q;
  logic [7:0]     sum_q;
  logic           wrap_q, cross_q;
  logic           out_valid_q;

  // working registers
  logic [31:0] next_slot_q, rgn_end_q, tail_q, pre_q, erase_addr_q, addr_q;
  logic        out_command_q, out_final_q;
  logic [31:0] out_addr_q, out_data_q;

  logic [31:0] stage_rdata, stored_rdata;
  logic        stage_we;
  logic        out_load, out_free;
  logic [7:0]  word_sum;
  logic [31:0] span;

  assign stage_we = cmd_i.stage_we && (word_count_q < WC_FULL);

  // staged record and last committed copy
  frlw_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stage_we),
    .waddr_i (word_count_q[AW-1:0]),
    .wdata_i (in_data_word_i),
    .raddr_i (idx_q),
    .rdata_o (stage_rdata)
  );

  frlw_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_stored_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ld_data),
    .waddr_i (idx_q),
    .wdata_i (stage_rdata),
    .raddr_i (idx_q),
    .rdata_o (stored_rdata)
  );

  // byte sum of one staged word
  assign word_sum = stage_rdata[7:0] + stage_rdata[15:8] + stage_rdata[23:16]
                  + stage_rdata[31:24];

  // region size in bytes
  assign span = 32'(region_pages_q) << PBL;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.ld_abandon || cmd_i.ld_erase || cmd_i.ld_data
                  || cmd_i.ld_trailer;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= frlw_pkg::REGION_START_RST;
      region_pages_q <= frlw_pkg::REGION_PAGES_RST;
      word_count_q   <= '0;
      func_q         <= frlw_pkg::FUNC_UPDATE;
      slot_q         <= frlw_pkg::REGION_START_RST;
      idx_q          <= '0;
      diff_q         <= 1'b0;
      sum_q          <= '0;
      wrap_q         <= 1'b0;
      cross_q        <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          frlw_pkg::CFG_REGION_START: region_start_q <= cfg_data_i;
          frlw_pkg::CFG_REGION_PAGES: region_pages_q <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      // word staging, commit start on the last beat
      if (cmd_i.stage_we) begin
        if (in_last_i) begin
          word_count_q <= '0;
          func_q       <= in_func_i;
          idx_q        <= '0;
          diff_q       <= 1'b0;
          sum_q        <= '0;
        end else if (word_count_q < WC_FULL) begin
          word_count_q <= word_count_q + WCW'(1);
        end
      end
      if (cmd_i.cmp_acc) begin
        sum_q  <= sum_q + word_sum;
        diff_q <= diff_q || (stage_rdata != stored_rdata);
      end
      if (cmd_i.ld_addr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      // slot overflow and page crossing
      if (cmd_i.calc_flags) begin
        wrap_q  <= (next_slot_q > rgn_end_q) || (next_slot_q < region_start_q)
                || (tail_q > rgn_end_q) || (tail_q < region_start_q);
        cross_q <= (tail_q[31:PBL] != pre_q[31:PBL]);
      end
      if (cmd_i.fmt_slot) begin
        slot_q <= region_start_q;
      end else if (cmd_i.sel_slot) begin
        slot_q <= wrap_q ? region_start_q : next_slot_q;
      end
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  // slot arithmetic and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_abandon) begin
      next_slot_q <= slot_q + SLOT_BYTES;
      rgn_end_q   <= region_start_q + span - 32'd1;
    end
    if (cmd_i.calc_tail) begin
      tail_q <= next_slot_q + SLOT_LAST;
      pre_q  <= next_slot_q - 32'd1;
    end
    if (cmd_i.fmt_slot) begin
      erase_addr_q <= region_start_q & PAGE_MASK;
    end else if (cmd_i.sel_slot) begin
      erase_addr_q <= (wrap_q ? region_start_q : tail_q) & PAGE_MASK;
    end
    if (cmd_i.ld_addr) begin
      addr_q <= slot_q + 32'd4;
    end else if (cmd_i.ld_data) begin
      addr_q <= addr_q + 32'd4;
    end
    if (cmd_i.ld_abandon) begin
      out_command_q <= frlw_pkg::CMD_PROGRAM;
      out_addr_q    <= slot_q;
      out_data_q    <= frlw_pkg::ABANDON_FLAG;
      out_final_q   <= 1'b0;
    end else if (cmd_i.ld_erase) begin
      out_command_q <= frlw_pkg::CMD_ERASE;
      out_addr_q    <= erase_addr_q;
      out_data_q    <= '0;
      out_final_q   <= 1'b0;
    end else if (cmd_i.ld_data) begin
      out_command_q <= frlw_pkg::CMD_PROGRAM;
      out_addr_q    <= addr_q;
      out_data_q    <= stage_rdata;
      out_final_q   <= 1'b0;
    end else if (cmd_i.ld_trailer) begin
      out_command_q <= frlw_pkg::CMD_PROGRAM;
      out_addr_q    <= addr_q;
      out_data_q    <= {16'h0000, sum_q, frlw_pkg::MAGIC_BYTE};
      out_final_q   <= 1'b1;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_command_o       = out_command_q;
  assign out_flash_address_o = out_addr_q;
  assign out_program_data_o  = out_data_q;
  assign out_final_res_o     = out_final_q;

  assign status_o.func       = func_q;
  assign status_o.diff       = diff_q;
  assign status_o.need_erase = wrap_q || cross_q;
  assign status_o.idx_last   = (idx_q == IDX_LAST);
  assign status_o.out_free   = out_free;

endmodule

/* hdl/flash_record_log_writer.sv */
// top level of the flash record log writer: sequencer plus datapath
// non-final record words take one cycle each; the final beat starts a commit
// commit: compare and byte sum; a changed update emits abandon flag, erase if needed,
//   data and trailer; a format erases, then data and trailer; unchanged emits nothing
// input is held off during a commit; reset clears control state, loads region registers
// PAGE_BYTES must be a power of two; the record rams are not cleared
`timescale 1ns / 1ps

module flash_record_log_writer #(
  parameter int unsigned DATA_WORDS = frlw_pkg::DATA_WORDS_DEF,
  parameter int unsigned PAGE_BYTES = frlw_pkg::PAGE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  frlw_in_if.sink                        in_i,
  frlw_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [frlw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  frlw_pkg::cmd_t    cmd;
  frlw_pkg::status_t status;
  logic              in_ready;

  assign in_i.ready = in_ready;

  // commit sequencer
  frlw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  frlw_dp #(
    .DATA_WORDS (DATA_WORDS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_func_i           (in_i.func),
    .in_data_word_i      (in_i.data_word),
    .in_last_i           (in_i.last),
    .out_valid_o         (out_o.valid),
    .out_ready_i         (out_o.ready),
    .out_command_o       (out_o.command),
    .out_flash_address_o (out_o.flash_address),
    .out_program_data_o  (out_o.program_data),
    .out_final_res_o     (out_o.final_res),
    .cmd_i               (cmd),
    .status_o            (status)
  );

endmodule

/* test/tb_flash_record_log_writer.sv */
// self-checking testbench for the flash record log writer
`timescale 1ns / 1ps

module tb_flash_record_log_writer;

  localparam int unsigned DW          = frlw_pkg::DATA_WORDS_DEF;
  localparam int unsigned PAGE_BYTES  = frlw_pkg::PAGE_BYTES_DEF;
  localparam int unsigned SLOT_BYTES  = 4 * DW + 8;
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    logic        func;
    logic [31:0] word;
    logic        last;
  } rec_beat_t;

  typedef struct {
    logic        command;
    logic [31:0] address;
    logic [31:0] data;
    logic        fin;
  } flash_cmd_t;

  typedef enum logic [1:0] {REC_FRESH, REC_REPEAT, REC_TWEAK} rec_kind_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [frlw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  frlw_in_if  rec_if ();
  frlw_out_if cmd_if ();

  flash_record_log_writer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (rec_if),
    .out_o       (cmd_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // stimulus and expected commands
  rec_beat_t   record_beats[$];
  flash_cmd_t  pending_flash_cmds[$];

  // shadow of the block's state for prediction
  logic [31:0] log_start;
  logic [8:0]  log_pages;
  logic [31:0] slot_ptr;
  logic [31:0] staged_rec [DW];
  logic [31:0] stored_rec [DW];
  int unsigned staged_cnt;

  // what the generator expects staging to hold
  logic [31:0] gen_rec [DW];
  int unsigned gen_cnt;
  int unsigned beats_queued;

  // pacing
  int unsigned idle_pct;
  bit          calm;
  int unsigned in_gap;
  int unsigned out_gap;
  bit          hold_for_drain;
  int unsigned quiet_cycles;

  // tallies
  int unsigned fail_cnt;
  int unsigned beats_in;
  int unsigned cmds_out;
  int unsigned n_formats;
  int unsigned n_updates;
  int unsigned n_unchanged;
  int unsigned n_wraps;
  int unsigned n_crossings;
  int unsigned n_settings;

  function automatic logic [31:0] page_of(logic [31:0] a);
    return (a / PAGE_BYTES) * PAGE_BYTES;
  endfunction

  function automatic void push_flash_cmd(logic cmd, logic [31:0] a, logic [31:0] d, logic f);
    pending_flash_cmds.push_back('{command: cmd, address: a, data: d, fin: f});
  endfunction

  // stage one record word; on the last word work out the commit's command burst
  task automatic log_record_beat(rec_beat_t b);
    logic [7:0]  sum;
    logic [31:0] region_end;
    logic [31:0] tail;
    bit          same;
    int          k;
    if (staged_cnt < DW) begin
      staged_rec[staged_cnt] = b.word;
      staged_cnt++;
    end
    if (!b.last) return;
    staged_cnt = 0;

    sum = 8'd0;
    for (k = 0; k < DW; k++) begin
      sum += staged_rec[k][7:0] + staged_rec[k][15:8] + staged_rec[k][23:16] +
             staged_rec[k][31:24];
    end

    if (b.func == frlw_pkg::FUNC_UPDATE) begin
      same = 1'b1;
      for (k = 0; k < DW; k++) begin
        if (staged_rec[k] != stored_rec[k]) same = 1'b0;
      end
      if (same) begin
        n_unchanged++;
        return;
      end
      n_updates++;
      // abandon the live slot, then step to the next one
      push_flash_cmd(frlw_pkg::CMD_PROGRAM, slot_ptr, frlw_pkg::ABANDON_FLAG, 1'b0);
      slot_ptr   = slot_ptr + SLOT_BYTES;
      region_end = log_start + 32'(log_pages) * PAGE_BYTES - 32'd1;
      tail       = slot_ptr + SLOT_BYTES - 32'd1;
      if (slot_ptr > region_end || slot_ptr < log_start ||
          tail > region_end || tail < log_start) begin
        n_wraps++;
        slot_ptr = log_start;
        push_flash_cmd(frlw_pkg::CMD_ERASE, page_of(log_start), 32'd0, 1'b0);
      end else if (tail / PAGE_BYTES != (slot_ptr - 32'd1) / PAGE_BYTES) begin
        n_crossings++;
        push_flash_cmd(frlw_pkg::CMD_ERASE, page_of(tail), 32'd0, 1'b0);
      end
    end else begin
      n_formats++;
      slot_ptr = log_start;
      push_flash_cmd(frlw_pkg::CMD_ERASE, page_of(log_start), 32'd0, 1'b0);
    end

    // data words, then the trailer closes the burst
    for (k = 0; k < DW; k++) begin
      stored_rec[k] = staged_rec[k];
      push_flash_cmd(frlw_pkg::CMD_PROGRAM, slot_ptr + 32'd4 + 32'(4 * k), staged_rec[k],
                     1'b0);
    end
    push_flash_cmd(frlw_pkg::CMD_PROGRAM, slot_ptr + 32'd4 + 32'(4 * DW),
                   {16'd0, sum, frlw_pkg::MAGIC_BYTE}, 1'b1);
  endtask

  // record word driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (rec_if.valid && rec_if.ready) begin
        log_record_beat(record_beats.pop_front());
        beats_in++;
      end
      if (hold_for_drain && pending_flash_cmds.size() == 0) hold_for_drain = 1'b0;
      if (!rec_if.valid || rec_if.ready) begin
        if (in_gap > 0 || hold_for_drain || record_beats.size() == 0) begin
          if (in_gap > 0) in_gap--;
          rec_if.valid <= 1'b0;
        end else begin
          rec_if.valid     <= 1'b1;
          rec_if.func      <= record_beats[0].func;
          rec_if.data_word <= record_beats[0].word;
          rec_if.last      <= record_beats[0].last;
          if (!calm && $urandom_range(0, 99) < idle_pct) begin
            in_gap = $urandom_range(1, 5);
          end else if (!calm && $urandom_range(0, 199) == 0) begin
            hold_for_drain = 1'b1;
          end
        end
      end
    end
  end

  // flash command monitor and checker
  always @(posedge clk) begin
    flash_cmd_t exp_cmd;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        cmds_out++;
        if (pending_flash_cmds.size() == 0) begin
          $error("unexpected command beat: command %0d address %h data %h final %0d",
                 cmd_if.command, cmd_if.flash_address, cmd_if.program_data, cmd_if.final_res);
          fail_cnt++;
        end else begin
          exp_cmd = pending_flash_cmds.pop_front();
          if (cmd_if.command !== exp_cmd.command) begin
            $error("command: expected %0d, got %0d", exp_cmd.command, cmd_if.command);
            fail_cnt++;
          end
          if (cmd_if.flash_address !== exp_cmd.address) begin
            $error("flash_address: expected %h, got %h", exp_cmd.address, cmd_if.flash_address);
            fail_cnt++;
          end
          if (cmd_if.program_data !== exp_cmd.data) begin
            $error("program_data: expected %h, got %h", exp_cmd.data, cmd_if.program_data);
            fail_cnt++;
          end
          if (cmd_if.final_res !== exp_cmd.fin) begin
            $error("final_res: expected %0d, got %0d", exp_cmd.fin, cmd_if.final_res);
            fail_cnt++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        cmd_if.ready <= 1'b0;
      end else begin
        cmd_if.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < idle_pct) out_gap = $urandom_range(1, 5);
      end
    end
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rec_if.valid && rec_if.ready) || (cmd_if.valid && cmd_if.ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] record_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_beat(logic fn, logic [31:0] w, logic l);
    if (gen_cnt < DW) begin
      gen_rec[gen_cnt] = w;
      gen_cnt++;
    end
    if (l) gen_cnt = 0;
    record_beats.push_back('{func: fn, word: w, last: l});
    beats_queued++;
  endfunction

  // one record; func on the non-final words is noise, only the last one counts
  function automatic void queue_record(logic fn, int unsigned n_words, rec_kind_e kind);
    int unsigned flip_w;
    int unsigned flip_b;
    int unsigned k;
    logic [31:0] w;
    logic        l;
    flip_w = $urandom_range(0, (n_words < DW ? n_words : DW) - 1);
    flip_b = $urandom_range(0, 31);
    for (k = 0; k < n_words; k++) begin
      l = (k == n_words - 1);
      if (k >= DW) begin
        w = $urandom();
      end else begin
        case (kind)
          REC_REPEAT: w = gen_rec[k];
          REC_TWEAK:  w = (k == flip_w) ? gen_rec[k] ^ (32'd1 << flip_b) : gen_rec[k];
          default:    w = record_word();
        endcase
      end
      queue_beat(l ? fn : logic'($urandom_range(0, 1)), w, l);
    end
  endfunction

  // mostly short records, some full, a few with surplus words
  function automatic void queue_random_records(int unsigned n_items);
    int unsigned goal;
    int unsigned len;
    int unsigned roll;
    logic        fn;
    rec_kind_e   kind;
    goal = beats_queued + n_items;
    while (beats_queued < goal) begin
      fn   = ($urandom_range(0, 99) < 10) ? frlw_pkg::FUNC_FORMAT : frlw_pkg::FUNC_UPDATE;
      roll = $urandom_range(0, 9);
      if (roll < 6)      len = $urandom_range(1, 3);
      else if (roll < 9) len = $urandom_range(4, DW);
      else               len = $urandom_range(DW + 1, DW + 3);
      roll = $urandom_range(0, 9);
      if (roll < 6)      kind = REC_FRESH;
      else if (roll < 8) kind = REC_REPEAT;
      else               kind = REC_TWEAK;
      queue_record(fn, len, kind);
    end
  endfunction

  // wait until every beat is in and every command out, then let the block go quiet
  task automatic settle();
    while (record_beats.size() != 0 || rec_if.valid || pending_flash_cmds.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_region(logic [31:0] start, logic [8:0] pages);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= frlw_pkg::CFG_REGION_START;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= frlw_pkg::CFG_REGION_PAGES;
    cfg_data  <= {23'd0, pages};
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    log_start = start;
    log_pages = pages;
    n_settings++;
  endtask

  task automatic run_phase(logic [31:0] start, logic [8:0] pages, bit fmt,
                           int unsigned n_items, int unsigned pct);
    settle();
    write_region(start, pages);
    idle_pct = pct;
    if (fmt) queue_record(frlw_pkg::FUNC_FORMAT, $urandom_range(1, DW), REC_FRESH);
    queue_random_records(n_items);
  endtask

  initial begin
    logic [31:0] corner [DW] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                                 32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
                                 32'h7FFF_FFFF, 32'hFFFF_FFFE};
    int k;
    rst_n            = 1'b0;
    rec_if.valid     = 1'b0;
    rec_if.func      = frlw_pkg::FUNC_UPDATE;
    rec_if.data_word = 32'd0;
    rec_if.last      = 1'b0;
    cmd_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = frlw_pkg::CFG_REGION_START;
    cfg_data         = 32'd0;
    log_start        = frlw_pkg::REGION_START_RST;
    log_pages        = frlw_pkg::REGION_PAGES_RST;
    slot_ptr         = frlw_pkg::REGION_START_RST;
    staged_cnt       = 0;
    gen_cnt          = 0;
    idle_pct         = 20;
    calm             = 1'b0;
    hold_for_drain   = 1'b0;
    in_gap           = 0;
    out_gap          = 0;
    quiet_cycles     = 0;
    for (k = 0; k < DW; k++) begin
      staged_rec[k] = 32'd0;
      stored_rec[k] = 32'd0;
      gen_rec[k]    = 32'd0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: full format of corner words, unchanged update, short and
    // one-bit-off update, surplus words, short format, format of an unchanged record
    for (k = 0; k < DW; k++) queue_beat(frlw_pkg::FUNC_FORMAT, corner[k], k == DW - 1);
    queue_record(frlw_pkg::FUNC_UPDATE, 1, REC_REPEAT);
    queue_record(frlw_pkg::FUNC_UPDATE, 2, REC_TWEAK);
    queue_record(frlw_pkg::FUNC_UPDATE, DW + 2, REC_FRESH);
    queue_record(frlw_pkg::FUNC_FORMAT, 1, REC_FRESH);
    queue_record(frlw_pkg::FUNC_FORMAT, 1, REC_REPEAT);

    // unaligned start puts the first new slot across a page boundary
    run_phase(32'h0000_07C0, 9'd2, 1'b1, 40, 25);
    // region that wraps past the top of the address space: every update wraps
    run_phase(32'hFFFF_F800, 9'd256, 1'b0, 30, 15);
    // park the slot pointer near the end of a one-page region
    run_phase(32'h0800_0700, 9'd1, 1'b1, 20, 30);
    run_phase(32'h0800_0000, 9'd1, 1'b0, 50, 0);
    run_phase(32'hFFFF_FFFF, 9'd1, 1'b0, 20, 20);
    run_phase(32'h0000_0000, 9'd256, 1'b1, 60, 10);
    run_phase($urandom() & 32'hFFFF_F800, 9'($urandom_range(1, 256)), 1'b1, 80, 35);
    calm = 1'b1;
    run_phase($urandom() & 32'hFFFF_F800, 9'($urandom_range(1, 8)), 1'b0, 70, 0);
    settle();

    $display("record beats in %0d, flash commands out %0d, %0d region settings",
             beats_in, cmds_out, n_settings);
    $display("formats %0d, updates written %0d, unchanged %0d, wraps %0d, page crossings %0d",
             n_formats, n_updates, n_unchanged, n_wraps, n_crossings);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* flash_record_log_writer.f */
hdl/frlw_pkg.sv
hdl/frlw_stream_if.sv
hdl/frlw_ram.sv
hdl/frlw_ctrl.sv
hdl/frlw_dp.sv
hdl/flash_record_log_writer.sv
test/tb_flash_record_log_writer.sv
